// ===== rtl/mandelbrot_escape_pixel_top_assert.svh =====
// Assertion macros shared by the escape-time pixel checker.
`ifndef MANDELBROT_ESCAPE_PIXEL_TOP_ASSERT_SVH
`define MANDELBROT_ESCAPE_PIXEL_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MEP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("escape pixel check failed");

// Consequent must hold in the cycle after the antecedent.
`define MEP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("escape pixel check failed");

`endif

// ===== rtl/mep_pkg.sv =====
// Shared types, constants and helper functions of the escape-time pixel engine.
package mep_pkg;

    localparam int WORD_W    = 32;   // Q-format word
    localparam int WIDE_W    = 64;   // product / intermediate width
    localparam int ITER_W    = 20;   // iteration limit register
    localparam int STEP_W    = 31;   // step registers
    localparam int IDX_W     = 14;   // column / row index
    localparam int COUNT_W   = 20;   // escape count port
    localparam int RGB_W     = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_X_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP   = 3'd4;

    localparam logic [ITER_W-1:0]        RST_MAX_ITER = 20'd256;
    localparam logic signed [WORD_W-1:0] RST_LEFT     = 32'shE000_0000;
    localparam logic signed [WORD_W-1:0] RST_LOWER    = 32'shF000_0000;
    localparam logic [STEP_W-1:0]        RST_STEP     = 31'h0010_0000;

    localparam int ESC_LIMIT = 4;                 // |z|^2 bound in integer units
    localparam logic [RGB_W-1:0] RED_HIGH = 8'd240;

    typedef struct packed {
        logic [RGB_W-1:0] red;
        logic [RGB_W-1:0] green;
        logic [RGB_W-1:0] blue;
    } t_rgb;

    function automatic logic signed [WIDE_W-1:0] sext_word(input logic signed [WORD_W-1:0] v);
        sext_word = {{(WIDE_W-WORD_W){v[WORD_W-1]}}, v};
    endfunction

    // Clamp a wide signed value to the word range.
    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WIDE_W-1:0] v);
        logic fits;
        fits = (v[WIDE_W-1:WORD_W-1] == '0) || (v[WIDE_W-1:WORD_W-1] == '1);
        if (fits) begin
            sat_word = v[WORD_W-1:0];
        end else if (v[WIDE_W-1]) begin
            sat_word = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            sat_word = {1'b0, {(WORD_W-1){1'b1}}};
        end
    endfunction

endpackage

// ===== rtl/mep_mul.sv =====
// Shared signed 32x32 multiplier with a registered product.
module mep_mul (
    input  logic                              i_clk,
    input  logic signed [mep_pkg::WORD_W-1:0] i_a,
    input  logic signed [mep_pkg::WORD_W-1:0] i_b,
    output logic signed [mep_pkg::WIDE_W-1:0] o_prod
);
    import mep_pkg::*;

    logic signed [WIDE_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= WIDE_W'(i_a) * WIDE_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/mep_color.sv =====
// Maps an escape count to the pixel colour.
module mep_color #(
    parameter int COUNT_BITS = 20
) (
    input  logic [COUNT_BITS-1:0] i_count,
    input  logic [COUNT_BITS-1:0] i_limit,
    output mep_pkg::t_rgb         o_rgb
);
    import mep_pkg::*;

    logic [RGB_W-1:0] w_k;

    // (count mod 16) * 16
    assign w_k = {i_count[3:0], 4'b0000};

    always_comb begin
        o_rgb = '0;
        if (i_count != i_limit) begin
            if (i_count[4]) begin
                o_rgb.red   = RED_HIGH;
                o_rgb.green = w_k;
                o_rgb.blue  = w_k;
            end else begin
                o_rgb.red = w_k;
            end
        end
    end

endmodule

// ===== rtl/mandelbrot_escape_pixel_top.sv =====
// Top level of the Mandelbrot escape-time pixel engine: sequencer and datapath.
//
// Usage:
//  - Input channel (i_in_valid / o_in_stall) carries one pixel as column and row.
//    A transaction completes on a clock edge with i_in_valid high and o_in_stall low.
//  - Output channel (o_out_valid / i_out_stall) carries escape count and RGB colour.
//  - Config port: i_cfg_we writes i_cfg_data into register i_cfg_index
//    (0 max_iterations, 1 left_edge, 2 lower_edge, 3 x_step, 4 y_step);
//    other indexes are ignored. Write only while the engine is idle.
//  - One pixel at a time. A single 32x32 multiplier is time-shared: the
//    products column*x_step and row*y_step build c, then each iteration
//    runs x*x, y*y, x*y and the z update in turn. The next pixel can be
//    taken in the cycle after the result is registered.
//  - The result sits in an output register; if the receiver stalls, a finished
//    pixel waits in the final state until the register frees up, and
//    o_in_stall stays high meanwhile.
//  - Reset (synchronous, active low) returns the sequencer to idle, drops
//    o_out_valid and loads the configuration defaults.
module mandelbrot_escape_pixel_top #(
    parameter int FRAC_BITS  = 28,
    parameter int COUNT_BITS = 20
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config write port
    input  logic                                i_cfg_we,
    input  logic [mep_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mep_pkg::WORD_W-1:0]          i_cfg_data,
    // pixel input
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [mep_pkg::IDX_W-1:0]           i_column,
    input  logic [mep_pkg::IDX_W-1:0]           i_row,
    // result output
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [mep_pkg::COUNT_W-1:0]         o_escape_count,
    output logic [mep_pkg::RGB_W-1:0]           o_red,
    output logic [mep_pkg::RGB_W-1:0]           o_green,
    output logic [mep_pkg::RGB_W-1:0]           o_blue
);
    import mep_pkg::*;

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CX   = 4'd1;  // column * x_step
    localparam logic [3:0] S_CY   = 4'd2;  // row * y_step, cx lands
    localparam logic [3:0] S_CZ   = 4'd3;  // cy lands, z cleared
    localparam logic [3:0] S_MXX  = 4'd4;  // x*x
    localparam logic [3:0] S_MYY  = 4'd5;  // y*y
    localparam logic [3:0] S_MXY  = 4'd6;  // x*y, escape / limit test
    localparam logic [3:0] S_UPD  = 4'd7;  // z update
    localparam logic [3:0] S_FIN  = 4'd8;  // hand result to output register

    logic [3:0] r_state, n_state;

    // configuration
    logic [ITER_W-1:0]        r_max_iter;
    logic signed [WORD_W-1:0] r_left;
    logic signed [WORD_W-1:0] r_lower;
    logic [STEP_W-1:0]        r_x_step;
    logic [STEP_W-1:0]        r_y_step;

    // per-pixel working state
    logic [IDX_W-1:0]         r_col;
    logic [IDX_W-1:0]         r_row;
    logic signed [WORD_W-1:0] r_cx;
    logic signed [WORD_W-1:0] r_cy;
    logic signed [WORD_W-1:0] r_x;
    logic signed [WORD_W-1:0] r_y;
    logic signed [WIDE_W-1:0] r_xx;
    logic signed [WIDE_W-1:0] r_diff;
    logic [COUNT_BITS-1:0]    r_count;

    // output register
    logic                     r_out_valid;
    logic [COUNT_W-1:0]       r_out_count;
    t_rgb                     r_out_rgb;

    logic signed [WORD_W-1:0] w_mul_a, w_mul_b;
    logic signed [WIDE_W-1:0] w_prod;
    logic [WIDE_W-1:0]        w_sq_sum;
    logic                     w_escaped;
    logic                     w_done;
    logic [COUNT_BITS-1:0]    w_limit;
    logic                     w_in_take;
    logic                     w_out_take;
    logic                     w_out_load;
    t_rgb                     w_rgb;

    assign w_limit    = COUNT_BITS'(r_max_iter);
    assign w_in_take  = i_in_valid && (r_state == S_IDLE);
    assign w_out_take = r_out_valid && !i_out_stall;
    assign w_out_load = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);

    // exact |z|^2 test: both squares are non-negative and fit unsigned
    assign w_sq_sum  = $unsigned(r_xx) + $unsigned(w_prod);
    assign w_escaped = ((w_sq_sum >> FRAC_BITS) >> FRAC_BITS) >= WIDE_W'(ESC_LIMIT);
    assign w_done    = w_escaped || (r_count == w_limit);

    // operand select for the shared multiplier
    always_comb begin
        case (r_state)
            S_CX: begin
                w_mul_a = $signed({{(WORD_W-IDX_W){1'b0}}, r_col});
                w_mul_b = $signed({1'b0, r_x_step});
            end
            S_CY: begin
                w_mul_a = $signed({{(WORD_W-IDX_W){1'b0}}, r_row});
                w_mul_b = $signed({1'b0, r_y_step});
            end
            S_MXX: begin
                w_mul_a = r_x;
                w_mul_b = r_x;
            end
            S_MYY: begin
                w_mul_a = r_y;
                w_mul_b = r_y;
            end
            S_MXY: begin
                w_mul_a = r_x;
                w_mul_b = r_y;
            end
            default: begin
                w_mul_a = r_x;
                w_mul_b = r_y;
            end
        endcase
    end

    mep_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    mep_color #(
        .COUNT_BITS (COUNT_BITS)
    ) u_color (
        .i_count (r_count),
        .i_limit (w_limit),
        .o_rgb   (w_rgb)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_in_take) n_state = S_CX;
            S_CX:    n_state = S_CY;
            S_CY:    n_state = S_CZ;
            S_CZ:    n_state = S_MXX;
            S_MXX:   n_state = S_MYY;
            S_MYY:   n_state = S_MXY;
            S_MXY:   n_state = w_done ? S_FIN : S_UPD;
            S_UPD:   n_state = S_MXX;
            S_FIN:   if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_max_iter  <= RST_MAX_ITER;
            r_left      <= RST_LEFT;
            r_lower     <= RST_LOWER;
            r_x_step    <= RST_STEP;
            r_y_step    <= RST_STEP;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (w_out_take) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MAX_ITER: r_max_iter <= i_cfg_data[ITER_W-1:0];
                    CFG_LEFT:     r_left     <= $signed(i_cfg_data);
                    CFG_LOWER:    r_lower    <= $signed(i_cfg_data);
                    CFG_X_STEP:   r_x_step   <= i_cfg_data[STEP_W-1:0];
                    CFG_Y_STEP:   r_y_step   <= i_cfg_data[STEP_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_take) begin
                    r_col <= i_column;
                    r_row <= i_row;
                end
            end
            S_CY: r_cx <= sat_word(sext_word(r_left) + w_prod);
            S_CZ: begin
                r_cy    <= sat_word(sext_word(r_lower) + w_prod);
                r_x     <= '0;
                r_y     <= '0;
                r_count <= '0;
            end
            S_MYY: r_xx <= w_prod;
            S_MXY: r_diff <= r_xx - w_prod;
            S_UPD: begin
                // floor shifts are arithmetic right shifts; 2xy folds into FRAC_BITS-1
                r_x     <= sat_word((r_diff >>> FRAC_BITS) + sext_word(r_cx));
                r_y     <= sat_word((w_prod >>> (FRAC_BITS - 1)) + sext_word(r_cy));
                r_count <= r_count + 1'b1;
            end
            S_FIN: begin
                if (w_out_load) begin
                    r_out_count <= COUNT_W'(r_count);
                    r_out_rgb   <= w_rgb;
                end
            end
            default: ;
        endcase
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_escape_count = r_out_count;
    assign o_red          = r_out_rgb.red;
    assign o_green        = r_out_rgb.green;
    assign o_blue         = r_out_rgb.blue;

endmodule

// ===== rtl/mep_checker.sv =====
// Port-level checker for the escape-time pixel engine, bound to the top level.
`include "mandelbrot_escape_pixel_top_assert.svh"

module mep_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [mep_pkg::COUNT_W-1:0]   o_escape_count,
    input logic [mep_pkg::RGB_W-1:0]     o_red,
    input logic [mep_pkg::RGB_W-1:0]     o_green,
    input logic [mep_pkg::RGB_W-1:0]     o_blue
);
    import mep_pkg::*;

    // stalled result keeps its valid and payload
    `MEP_ASSERT_NEXT(a_out_valid_hold, o_out_valid && i_out_stall, o_out_valid)
    `MEP_ASSERT_NEXT(a_out_data_hold, o_out_valid && i_out_stall, $stable(o_escape_count) && $stable(o_red) && $stable(o_green) && $stable(o_blue))

    // one pixel at a time: busy right after a transaction
    `MEP_ASSERT_NEXT(a_busy_after_take, i_in_valid && !o_in_stall, o_in_stall)

    // a new result only comes out of a busy engine
    `MEP_ASSERT_SAME(a_result_from_busy, $rose(o_out_valid), $past(o_in_stall))

    // a zero count only happens with a zero limit, which is black
    `MEP_ASSERT_SAME(a_zero_count_black, o_out_valid && (o_escape_count == '0), (o_red == '0) && (o_green == '0) && (o_blue == '0))

endmodule

bind mandelbrot_escape_pixel_top mep_checker u_mep_checker (.*);

// ===== test/mandelbrot_escape_pixel_top_test.sv =====
// Self-checking testbench for the Mandelbrot escape-time pixel engine.
`timescale 1ns / 1ps

localparam int FRAC_BITS  = 28;
localparam int COUNT_BITS = 20;

localparam longint WORD_HI = (longint'(1) << 31) - 1;
localparam longint WORD_LO = -(longint'(1) << 31);

typedef struct packed {
    logic [mep_pkg::IDX_W-1:0]   column;
    logic [mep_pkg::IDX_W-1:0]   row;
    logic [mep_pkg::COUNT_W-1:0] count;
    mep_pkg::t_rgb               rgb;
} t_pixel_outcome;

// Tracks the register copy, the colours still owed and the mismatch count.
class pixel_ledger;
    logic [mep_pkg::ITER_W-1:0]        limit;
    logic signed [mep_pkg::WORD_W-1:0] left_re;
    logic signed [mep_pkg::WORD_W-1:0] lower_im;
    logic [mep_pkg::STEP_W-1:0]        step_re;
    logic [mep_pkg::STEP_W-1:0]        step_im;
    t_pixel_outcome                    awaiting[$];
    int                                mismatches;
    int                                checked;

    function new();
        limit      = mep_pkg::RST_MAX_ITER;
        left_re    = mep_pkg::RST_LEFT;
        lower_im   = mep_pkg::RST_LOWER;
        step_re    = mep_pkg::RST_STEP;
        step_im    = mep_pkg::RST_STEP;
        mismatches = 0;
        checked    = 0;
    endfunction

    function void apply_reg(logic [mep_pkg::CFG_IDX_W-1:0] idx,
                            logic [mep_pkg::WORD_W-1:0] data);
        case (idx)
            mep_pkg::CFG_MAX_ITER: limit    = data[mep_pkg::ITER_W-1:0];
            mep_pkg::CFG_LEFT:     left_re  = data;
            mep_pkg::CFG_LOWER:    lower_im = data;
            mep_pkg::CFG_X_STEP:   step_re  = data[mep_pkg::STEP_W-1:0];
            mep_pkg::CFG_Y_STEP:   step_im  = data[mep_pkg::STEP_W-1:0];
            default: ;
        endcase
    endfunction

    static function longint clamp_word(longint v);
        if (v > WORD_HI) return WORD_HI;
        if (v < WORD_LO) return WORD_LO;
        return v;
    endfunction

    // Escape count and colour of one pixel under the current registers.
    function t_pixel_outcome escape_time_of(logic [mep_pkg::IDX_W-1:0] col,
                                            logic [mep_pkg::IDX_W-1:0] row);
        t_pixel_outcome res;
        longint cx, cy, x, y, re, im;
        logic [63:0] mag;
        logic [mep_pkg::COUNT_W-1:0] n;
        logic [mep_pkg::RGB_W-1:0] shade;
        bit gone;
        cx = clamp_word(longint'(left_re) + longint'(col) * longint'(step_re));
        cy = clamp_word(longint'(lower_im) + longint'(row) * longint'(step_im));
        x = 0;
        y = 0;
        n = '0;
        gone = 1'b0;
        while (n < limit && !gone) begin
            re = ((x * x - y * y) >>> FRAC_BITS) + cx;
            im = ((x * y) >>> (FRAC_BITS - 1)) + cy;
            x = clamp_word(re);
            y = clamp_word(im);
            // exact |z|^2 against 4, no rounding
            mag = 64'(x * x) + 64'(y * y);
            gone = (mag >> (2 * FRAC_BITS)) >= mep_pkg::ESC_LIMIT;
            n++;
        end
        res.column = col;
        res.row    = row;
        res.count  = n;
        res.rgb    = '0;
        if (n != limit) begin
            shade = {n[3:0], 4'b0000};
            if (n[4]) begin
                res.rgb.red   = mep_pkg::RED_HIGH;
                res.rgb.green = shade;
                res.rgb.blue  = shade;
            end else begin
                res.rgb.red = shade;
            end
        end
        return res;
    endfunction

    function void note_pixel(logic [mep_pkg::IDX_W-1:0] col,
                             logic [mep_pkg::IDX_W-1:0] row);
        awaiting.push_back(escape_time_of(col, row));
    endfunction

    task report(string msg);
        if (mismatches < 40) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        mismatches++;
    endtask

    task compare_field(t_pixel_outcome want, string what, logic [31:0] got,
                       logic [31:0] exp);
        if (got !== exp) begin
            report($sformatf("pixel (%0d,%0d) %s got %0d expected %0d",
                             want.column, want.row, what, got, exp));
        end
    endtask

    task check_result(logic [mep_pkg::COUNT_W-1:0] count, logic [mep_pkg::RGB_W-1:0] red,
                      logic [mep_pkg::RGB_W-1:0] green, logic [mep_pkg::RGB_W-1:0] blue);
        t_pixel_outcome want;
        if (awaiting.size() == 0) begin
            report($sformatf("result with count %0d and no pixel outstanding", count));
        end else begin
            want = awaiting.pop_front();
            checked++;
            compare_field(want, "escape_count", 32'(count), 32'(want.count));
            compare_field(want, "red", 32'(red), 32'(want.rgb.red));
            compare_field(want, "green", 32'(green), 32'(want.rgb.green));
            compare_field(want, "blue", 32'(blue), 32'(want.rgb.blue));
        end
    endtask
endclass

module mandelbrot_escape_pixel_top_test;
    import mep_pkg::*;

    // No transaction on either channel for this many cycles ends the run.
    // The limit covers the slowest legal pixel plus sender gaps and stalls.
    localparam int QUIET_LIMIT  = 20000;
    localparam int RANDOM_ITEMS = 1600;
    localparam int CFG_SLOTS    = 1 << CFG_IDX_W;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [WORD_W-1:0]    i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [IDX_W-1:0]     i_column;
    logic [IDX_W-1:0]     i_row;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [COUNT_W-1:0]   o_escape_count;
    logic [RGB_W-1:0]     o_red;
    logic [RGB_W-1:0]     o_green;
    logic [RGB_W-1:0]     o_blue;

    pixel_ledger ledger;
    int          stall_pct;     // chance per cycle that the result side starts a stall
    bit          gaps_on;       // sender may idle between transactions
    int          sent_items;
    int          settings;

    wire in_fire  = i_in_valid && !o_in_stall;
    wire out_fire = o_out_valid && !i_out_stall;

    mandelbrot_escape_pixel_top #(
        .FRAC_BITS  (FRAC_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_column       (i_column),
        .i_row          (i_row),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_escape_count (o_escape_count),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue)
    );

    always #10 i_clk = ~i_clk;

    // Idle lengths: mostly a few cycles, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 100);
    endfunction

    // Both channels are sampled at the edge, so values seen here are the
    // ones the block acted on. Inputs are noted before the next one is driven.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_fire) begin
                ledger.note_pixel(i_column, i_row);
            end
            if (out_fire) begin
                ledger.check_result(o_escape_count, o_red, o_green, o_blue);
            end
        end
    end

    // Result-side backpressure; stall_pct of zero gives stall-free stretches.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_pct == 0 || $urandom_range(0, 99) >= stall_pct) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b1;
                repeat (pick_gap()) @(posedge i_clk);
            end
        end
    end

    // Watchdog: counts edges with no transaction on either channel.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || in_fire || out_fire) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
        $display("FAIL");
        $finish;
    end

    // One pixel transaction; payload holds while stalled. Valid stays high
    // into the next call unless a gap is taken.
    task automatic send_pixel(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] row);
        int gap;
        i_in_valid <= 1'b1;
        i_column   <= col;
        i_row      <= row;
        do @(posedge i_clk); while (o_in_stall);
        sent_items++;
        if (gaps_on && $urandom_range(0, 1) == 0) begin
            gap = pick_gap();
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait for every owed result. The first edge lets the
    // monitor note the last accepted pixel before the queue is looked at.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (ledger.awaiting.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        ledger.apply_reg(idx, data);
        @(posedge i_clk);
    endtask

    // Full register set; unused upper data bits are random, and one write
    // goes to an index past the register file.
    task automatic program_window(input logic [ITER_W-1:0] lim,
                                  input logic [WORD_W-1:0] left,
                                  input logic [WORD_W-1:0] lower,
                                  input logic [STEP_W-1:0] xs,
                                  input logic [STEP_W-1:0] ys);
        logic [WORD_W-1:0]    data;
        logic [CFG_IDX_W-1:0] spare;
        data = $urandom();
        data[ITER_W-1:0] = lim;
        write_reg(CFG_MAX_ITER, data);
        write_reg(CFG_LEFT, left);
        write_reg(CFG_LOWER, lower);
        data = $urandom();
        data[STEP_W-1:0] = xs;
        write_reg(CFG_X_STEP, data);
        data = $urandom();
        data[STEP_W-1:0] = ys;
        write_reg(CFG_Y_STEP, data);
        spare = CFG_IDX_W'($urandom_range(int'(CFG_Y_STEP) + 1, CFG_SLOTS - 1));
        write_reg(spare, $urandom());
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    initial begin
        int                roll;
        int                phase_len;
        bit                far;
        logic [ITER_W-1:0] lim;
        logic [WORD_W-1:0] left;
        logic [WORD_W-1:0] lower;
        logic [STEP_W-1:0] xs;
        logic [STEP_W-1:0] ys;
        logic [IDX_W-1:0]  col;
        logic [IDX_W-1:0]  row;

        ledger      = new();
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_column    = '0;
        i_row       = '0;
        stall_pct   = 20;
        gaps_on     = 1'b1;
        sent_items  = 0;
        settings    = 1;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset window: c = (-2 + col/256, -1 + row/256), limit 256.
        send_pixel(14'd0, 14'd0);           // |c| > 2, leaves on the first step
        send_pixel(14'd384, 14'd256);       // c = -0.5, inside: black
        send_pixel(14'd448, 14'd256);       // c = -0.25, inside
        send_pixel(14'd300, 14'd256);       // period-two bulb
        send_pixel(14'd576, 14'd256);       // cusp at 0.25, slow, stays to the limit
        send_pixel(14'd600, 14'd256);       // just past the cusp, escapes late
        send_pixel(14'd512, 14'd512);       // c = i, bounded orbit
        send_pixel(14'd16383, 14'd16383);   // both parts of c clamp high
        send_pixel(14'd16383, 14'd0);
        send_pixel(14'd0, 14'd16383);
        settle();

        // Zero limit: no iteration, count equals limit, black.
        program_window('0, RST_LEFT, RST_LOWER, RST_STEP, RST_STEP);
        send_pixel(14'd384, 14'd256);
        send_pixel(14'd0, 14'd0);
        settle();

        // Limit of one: escaping or not, the count hits the limit.
        program_window(20'd1, RST_LEFT, RST_LOWER, RST_STEP, RST_STEP);
        send_pixel(14'd384, 14'd256);
        send_pixel(14'd0, 14'd0);
        settle();

        // Largest limit with the window pinned far right: one step each.
        program_window('1, 32'h7FFF_FFFF, 32'h8000_0000, '1, '0);
        send_pixel(14'd0, 14'd0);
        send_pixel(14'd16383, 14'd16383);
        settle();

        // Most negative left edge, largest lower edge and y step.
        program_window('1, 32'h8000_0000, 32'h7FFF_FFFF, '0, '1);
        send_pixel(14'd0, 14'd0);
        send_pixel(14'd5, 14'd9);
        settle();

        // Random phases: a fresh register set, a burst of pixels, drain.
        sent_items = 0;
        while (sent_items < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 99);
            far  = 1'b0;
            if (roll < 3) begin
                lim = '0;
            end else if (roll < 11) begin
                lim = RST_MAX_ITER;
            end else if (roll < 16) begin
                lim = '1;
                far = 1'b1;
            end else if (roll < 30) begin
                lim = ITER_W'($urandom_range(1, 4));
            end else begin
                lim = ITER_W'($urandom_range(5, 48));
            end

            if (far) begin
                // real part of c at least 4: every pixel leaves on step one
                left  = $urandom_range(32'h4000_0000, 32'h7FFF_FFFF);
                lower = $urandom();
                xs    = STEP_W'($urandom());
                ys    = STEP_W'($urandom());
            end else if ($urandom_range(0, 5) == 0) begin
                // anything goes: clamped c, huge steps
                left  = $urandom();
                lower = $urandom();
                xs    = STEP_W'($urandom());
                ys    = STEP_W'($urandom());
            end else begin
                // around the set: left in [-2.5, 0.5], lower in [-1.5, 0]
                left  = $urandom_range(0, 32'h3000_0000) - 32'h2800_0000;
                lower = $urandom_range(0, 32'h1800_0000) - 32'h1800_0000;
                xs    = ($urandom_range(0, 9) == 0) ? '0 : STEP_W'($urandom_range(0, 1 << 21));
                ys    = ($urandom_range(0, 9) == 0) ? '0 : STEP_W'($urandom_range(0, 1 << 21));
            end
            program_window(lim, left, lower, xs, ys);

            phase_len = (lim == RST_MAX_ITER) ? $urandom_range(8, 20) : $urandom_range(20, 80);
            gaps_on   = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 2))
                0:       stall_pct = 0;
                1:       stall_pct = 15;
                default: stall_pct = 50;
            endcase

            repeat (phase_len) begin
                col = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom_range(0, 16383))
                                                  : IDX_W'($urandom_range(0, 511));
                row = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom_range(0, 16383))
                                                  : IDX_W'($urandom_range(0, 511));
                send_pixel(col, row);
            end
            settle();
        end

        // Quiet tail: anything arriving now has no pixel behind it.
        repeat (64) @(posedge i_clk);

        $display("%0d results checked over %0d register settings", ledger.checked, settings);
        $display("limits from zero to full width, clamped windows, stalls and gaps on both sides");
        if (ledger.mismatches == 0 && ledger.awaiting.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
